>>> rtl/utf8e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8e_pkg: shared types and constants of the UTF-8 encoder
// Payload structs of both channels, register indexes and code point bounds.
// ----------------------------------------------------------------------------
package utf8e_pkg;

  localparam int unsigned CP_W      = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned CNT_W     = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 1'd1;

  // first code point that has no encoding
  localparam logic [CP_W-1:0] CP_LIMIT = 31'h0011_0000;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            string_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_end;
    logic       bad_code;
  } out_item_t;

endpackage : utf8e_pkg
`default_nettype wire

>>> rtl/utf8_encode_with_byte_limit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_encode_with_byte_limit_core: UTF-8 encoder with per-string byte limit
// The first byte of a character is on the output in the cycle after its transfer.
// A character of n bytes (1..4) holds the byte buffer until its last byte has
//   transferred; an item that emits nothing leaves it empty. The next item is
//   taken in the cycle the last byte of the previous character transfers.
// Reset (rst_n, synchronous): byte buffer empty, count and stop flag cleared,
//   limit disabled, byte limit zero.
// ----------------------------------------------------------------------------
module utf8_encode_with_byte_limit_core
  import utf8e_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  // configuration registers
  logic             limit_enable_r;
  logic [CNT_W-1:0] byte_limit_r;

  // string state
  logic [CNT_W-1:0] bytes_emitted_r, bytes_emitted_nxt;
  logic             stopped_r, stopped_nxt;

  // byte buffer holding one encoded character
  logic [3:0][7:0]  buf_bytes_r, buf_bytes_nxt;
  logic [1:0]       buf_len_r, buf_len_nxt;     // byte count minus one
  logic [1:0]       buf_idx_r, buf_idx_nxt;
  logic             buf_bad_r, buf_bad_nxt;
  logic             buf_valid_r, buf_valid_nxt;

  logic             in_xfer, out_xfer, buf_last;

  // encode path
  logic [CP_W-1:0]  cp;
  logic [CNT_W-1:0] base_cnt;
  logic             base_stop;
  logic             cp_bad;
  logic [2:0]       enc_n;
  logic [3:0][7:0]  enc_bytes;
  logic [CNT_W:0]   total;
  logic             over_limit;

  assign buf_last = (buf_idx_r == buf_len_r);
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = buf_valid_r && !(buf_last && !out_stall);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid         = buf_valid_r;
  assign out_data.out_byte = buf_bad_r ? 8'h00 : buf_bytes_r[buf_idx_r];
  assign out_data.char_end = !buf_bad_r && buf_last;
  assign out_data.bad_code = buf_bad_r;

  always_comb begin
    cp        = in_data.code_point;
    base_cnt  = in_data.string_start ? '0 : bytes_emitted_r;
    base_stop = in_data.string_start ? 1'b0 : stopped_r;
    cp_bad    = (cp >= CP_LIMIT);
    enc_bytes = '0;
    if (cp[CP_W-1:7] == '0) begin
      enc_n        = 3'd1;
      enc_bytes[0] = cp[7:0];
    end else if (cp[CP_W-1:11] == '0) begin
      enc_n        = 3'd2;
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[CP_W-1:16] == '0) begin
      enc_n        = 3'd3;
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc_n        = 3'd4;
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
    end
    total      = {1'b0, base_cnt} + {{(CNT_W-2){1'b0}}, enc_n};
    over_limit = limit_enable_r && (total > {1'b0, byte_limit_r});
  end

  always_comb begin
    bytes_emitted_nxt = bytes_emitted_r;
    stopped_nxt       = stopped_r;
    buf_bytes_nxt     = buf_bytes_r;
    buf_len_nxt       = buf_len_r;
    buf_idx_nxt       = buf_idx_r;
    buf_bad_nxt       = buf_bad_r;
    buf_valid_nxt     = buf_valid_r;

    if (out_xfer) begin
      if (buf_last) begin
        buf_valid_nxt = 1'b0;
      end else begin
        buf_idx_nxt = buf_idx_r + 2'd1;
      end
    end

    if (in_xfer) begin
      bytes_emitted_nxt = base_cnt;
      stopped_nxt       = base_stop;
      if (!base_stop) begin
        if (cp_bad) begin
          stopped_nxt   = 1'b1;
          buf_valid_nxt = 1'b1;
          buf_bad_nxt   = 1'b1;
          buf_len_nxt   = 2'd0;
          buf_idx_nxt   = 2'd0;
        end else if (over_limit) begin
          stopped_nxt = 1'b1;
        end else begin
          buf_valid_nxt = 1'b1;
          buf_bad_nxt   = 1'b0;
          buf_bytes_nxt = enc_bytes;
          buf_len_nxt   = 2'(enc_n - 3'd1);
          buf_idx_nxt   = 2'd0;
          // count saturates at all ones
          bytes_emitted_nxt = total[CNT_W] ? '1 : total[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_enable_r  <= 1'b0;
      byte_limit_r    <= '0;
      bytes_emitted_r <= '0;
      stopped_r       <= 1'b0;
      buf_valid_r     <= 1'b0;
      buf_idx_r       <= '0;
      buf_len_r       <= '0;
      buf_bad_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT_ENABLE: limit_enable_r <= cfg_wdata[0];
          CFG_BYTE_LIMIT:   byte_limit_r   <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      bytes_emitted_r <= bytes_emitted_nxt;
      stopped_r       <= stopped_nxt;
      buf_valid_r     <= buf_valid_nxt;
      buf_idx_r       <= buf_idx_nxt;
      buf_len_r       <= buf_len_nxt;
      buf_bad_r       <= buf_bad_nxt;
    end
  end

  // payload bytes, no reset
  always_ff @(posedge clk) begin
    buf_bytes_r <= buf_bytes_nxt;
  end

  // an item is only taken into a busy buffer as its last result leaves
  a_in_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && buf_valid_r) |-> (out_xfer && (out_data.char_end || out_data.bad_code)))
    else $error("input taken while buffer still holds bytes");

  // error results carry no byte and no character end
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_code) |-> (out_data.out_byte == 8'h00 && !out_data.char_end))
    else $error("error result carries byte data");

  // a partial character advances by one byte per transfer
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !buf_last) |=> (out_valid && buf_idx_r == $past(buf_idx_r) + 2'd1))
    else $error("byte index did not advance");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule : utf8_encode_with_byte_limit_core
`default_nettype wire
